// ===== rtl/tcr_pkg.sv =====
// Types, constant wiring tables and letter arithmetic for the three-rotor cipher.
package tcr_pkg;

    localparam logic [5:0] LETTERS = 6'd26;
    localparam int BACK_STAGES = 10;
    localparam int PAIR_COUNT = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 50;

    localparam logic [CFG_IDX_W-1:0] CFG_ROTOR_TYPES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFLECTOR       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_SETTINGS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POSITIONS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLUG_PAIRS_A    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLUG_PAIRS_B    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PLUG_PAIRS_C    = 3'd6;

    localparam logic [3:0] SEL_IDENTITY  = 4'd8;
    localparam logic [1:0] REFL_IDENTITY = 2'd2;

    typedef logic [4:0] t_letter;
    typedef logic [9:0] t_pair;
    typedef logic [25:0][4:0] t_wheel;
    typedef t_wheel [8:0] t_wheel_set;
    typedef t_wheel [2:0] t_refl_set;

    typedef struct packed {
        logic [3:0] sel_l;
        logic [3:0] sel_m;
        logic [3:0] sel_r;
        logic [1:0] refl;
        t_letter    ring_l;
        t_letter    ring_m;
        t_letter    ring_r;
        t_pair [PAIR_COUNT-1:0] pairs;
    } t_cfg;

    typedef struct packed {
        t_letter letter;
        t_letter pos_r;
        t_letter pos_m;
        t_letter pos_l;
    } t_item;

    typedef struct packed {
        t_letter c;
        t_letter off_r;
        t_letter off_m;
        t_letter off_l;
        t_letter pos_r;
        t_letter pos_m;
        t_letter pos_l;
    } t_work;

    localparam logic [8:0][207:0] WHEEL_TXT = {
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
        "FKQHTLXOCBJSPDZRAMEWNIUYGV",
        "NZJHGRCXMYSWBOUFAIVLPEKQDT",
        "JPGVOUMFYQBENHZRDKASXLICTW",
        "VZBRGITYUPSDNHLXAWMJQOFECK",
        "ESOVPZJAYQUIRHXLNFTGKDCMWB",
        "BDFHJLCPRTXVZNYEIWGAKMUSQO",
        "AJDKSIRUXBLHWTMCQGZNPYFVOE",
        "EKMFLGDQVZNTOWYHXUSPAIBRCJ"
    };

    localparam logic [2:0][207:0] REFL_TXT = {
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
        "FVPJIAOYEDRZXWGCTKUQSBNMHL",
        "YRUHQSLDPXNGOKMIEBFZCWVJAT"
    };

    function automatic t_wheel text_to_wheel(input logic [207:0] txt);
        logic [7:0] ch;
        t_wheel w;
        for (int i = 0; i < 26; i++) begin
            ch = txt[(25 - i) * 8 +: 8];
            w[i] = 5'(ch - 8'd65);
        end
        return w;
    endfunction

    function automatic t_wheel_set build_fwd();
        t_wheel_set w;
        for (int s = 0; s < 9; s++) begin
            w[s] = text_to_wheel(WHEEL_TXT[s]);
        end
        return w;
    endfunction

    localparam t_wheel_set WHEEL_FWD = build_fwd();

    function automatic t_wheel_set build_inv();
        t_wheel_set w;
        w = '0;
        for (int s = 0; s < 9; s++) begin
            for (int i = 0; i < 26; i++) begin
                w[s][WHEEL_FWD[s][i]] = 5'(i);
            end
        end
        return w;
    endfunction

    localparam t_wheel_set WHEEL_INV = build_inv();

    function automatic t_refl_set build_refl();
        t_refl_set w;
        for (int s = 0; s < 3; s++) begin
            w[s] = text_to_wheel(REFL_TXT[s]);
        end
        return w;
    endfunction

    localparam t_refl_set REFL_MAP = build_refl();

    function automatic t_letter reduce26(input t_letter x);
        logic [5:0] s;
        s = {1'b0, x};
        if (s >= LETTERS) begin
            s = s - LETTERS;
        end
        return s[4:0];
    endfunction

    function automatic t_letter mod_add(input t_letter a, input t_letter b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= LETTERS) begin
            s = s - LETTERS;
        end
        return s[4:0];
    endfunction

    function automatic t_letter mod_sub(input t_letter a, input t_letter b);
        logic [5:0] neg;
        neg = LETTERS - {1'b0, b};
        return mod_add(a, neg[4:0]);
    endfunction

    function automatic t_letter inc26(input t_letter p);
        return (p == 5'd25) ? 5'd0 : p + 5'd1;
    endfunction

    function automatic logic at_notch(input logic [3:0] sel, input t_letter pos);
        logic hit;
        unique case (sel) inside
            4'd0:             hit = (pos == 5'd16);
            4'd1:             hit = (pos == 5'd4);
            4'd2:             hit = (pos == 5'd21);
            4'd3:             hit = (pos == 5'd9);
            4'd4:             hit = (pos == 5'd25);
            4'd5, 4'd6, 4'd7: hit = (pos == 5'd12) || (pos == 5'd25);
            default:          hit = (pos == 5'd0);
        endcase
        return hit;
    endfunction

    function automatic t_letter rotor_pass(input t_letter c, input logic [3:0] sel,
                                           input t_letter off, input logic back);
        t_letter idx;
        t_letter v;
        idx = mod_add(c, off);
        v = back ? WHEEL_INV[sel][idx] : WHEEL_FWD[sel][idx];
        return mod_sub(v, off);
    endfunction

    function automatic t_letter apply_pair(input t_letter x, input t_pair p);
        t_letter r;
        r = x;
        if ((p[4:0] < 5'd26) && (p[9:5] < 5'd26)) begin
            if (x == p[4:0]) begin
                r = p[9:5];
            end else if (x == p[9:5]) begin
                r = p[4:0];
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/tcr_front.sv =====
// Front end: accepts letters, steps the rotor positions and pushes work items.
module tcr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tcr_pkg::t_cfg   i_cfg,
    input  logic            i_load,
    input  logic [14:0]     i_load_pos,
    input  logic            i_valid,
    input  tcr_pkg::t_letter i_letter,
    output logic            o_stall,
    input  logic            i_full,
    output logic            o_push,
    output tcr_pkg::t_item  o_item
);

    tcr_pkg::t_letter r_pos_r, r_pos_m, r_pos_l;
    tcr_pkg::t_letter n_pos_r, n_pos_m, n_pos_l;
    logic mid_notch;
    logic right_notch;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        mid_notch   = tcr_pkg::at_notch(i_cfg.sel_m, r_pos_m);
        right_notch = tcr_pkg::at_notch(i_cfg.sel_r, r_pos_r);
        n_pos_r = tcr_pkg::inc26(r_pos_r);
        n_pos_m = (mid_notch || right_notch) ? tcr_pkg::inc26(r_pos_m) : r_pos_m;
        n_pos_l = mid_notch ? tcr_pkg::inc26(r_pos_l) : r_pos_l;
        o_item.letter = tcr_pkg::reduce26(i_letter);
        o_item.pos_r  = n_pos_r;
        o_item.pos_m  = n_pos_m;
        o_item.pos_l  = n_pos_l;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_r <= '0;
            r_pos_m <= '0;
            r_pos_l <= '0;
        end else if (i_load) begin
            r_pos_r <= tcr_pkg::reduce26(i_load_pos[4:0]);
            r_pos_m <= tcr_pkg::reduce26(i_load_pos[9:5]);
            r_pos_l <= tcr_pkg::reduce26(i_load_pos[14:10]);
        end else if (o_push) begin
            r_pos_r <= n_pos_r;
            r_pos_m <= n_pos_m;
            r_pos_l <= n_pos_l;
        end
    end

endmodule

// ===== rtl/tcr_queue.sv =====
// Short queue of work items between the front end and the cipher pipeline.
module tcr_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcr_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output tcr_pkg::t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    tcr_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/tcr_back.sv =====
// Cipher pipeline: plugboard, rotors, reflector, rotors back, plugboard, output register.
module tcr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tcr_pkg::t_cfg    i_cfg,
    input  logic             i_q_valid,
    input  tcr_pkg::t_item   i_q_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output tcr_pkg::t_letter o_cipher_letter,
    output tcr_pkg::t_letter o_right_pos_out,
    output tcr_pkg::t_letter o_middle_pos_out,
    output tcr_pkg::t_letter o_left_pos_out
);

    localparam int NSTG = tcr_pkg::BACK_STAGES;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] ld;
    logic [NSTG-1:0] vin;
    tcr_pkg::t_work r_wk [NSTG];
    tcr_pkg::t_work n_wk [NSTG];

    always_comb begin
        ld[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
        vin[0] = i_q_valid;
        for (int k = 1; k < NSTG; k++) begin
            vin[k] = r_vld[k-1];
        end
    end

    assign o_pop = i_q_valid && ld[0];

    always_comb begin
        tcr_pkg::t_letter c0;
        tcr_pkg::t_letter c1;
        tcr_pkg::t_letter c8;
        tcr_pkg::t_letter c9;
        tcr_pkg::t_letter refl;
        c0 = i_q_item.letter;
        for (int k = 12; k >= 6; k--) begin
            c0 = tcr_pkg::apply_pair(c0, i_cfg.pairs[k]);
        end
        c1 = r_wk[0].c;
        for (int k = 5; k >= 0; k--) begin
            c1 = tcr_pkg::apply_pair(c1, i_cfg.pairs[k]);
        end
        c8 = r_wk[7].c;
        for (int k = 12; k >= 6; k--) begin
            c8 = tcr_pkg::apply_pair(c8, i_cfg.pairs[k]);
        end
        c9 = r_wk[8].c;
        for (int k = 5; k >= 0; k--) begin
            c9 = tcr_pkg::apply_pair(c9, i_cfg.pairs[k]);
        end
        refl = tcr_pkg::REFL_MAP[i_cfg.refl][r_wk[4].c];
        n_wk[0].c     = c0;
        n_wk[0].off_r = tcr_pkg::mod_sub(i_q_item.pos_r, i_cfg.ring_r);
        n_wk[0].off_m = tcr_pkg::mod_sub(i_q_item.pos_m, i_cfg.ring_m);
        n_wk[0].off_l = tcr_pkg::mod_sub(i_q_item.pos_l, i_cfg.ring_l);
        n_wk[0].pos_r = i_q_item.pos_r;
        n_wk[0].pos_m = i_q_item.pos_m;
        n_wk[0].pos_l = i_q_item.pos_l;
        for (int k = 1; k < NSTG; k++) begin
            n_wk[k] = r_wk[k-1];
        end
        n_wk[1].c = c1;
        n_wk[2].c = tcr_pkg::rotor_pass(r_wk[1].c, i_cfg.sel_r, r_wk[1].off_r, 1'b0);
        n_wk[3].c = tcr_pkg::rotor_pass(r_wk[2].c, i_cfg.sel_m, r_wk[2].off_m, 1'b0);
        n_wk[4].c = tcr_pkg::rotor_pass(r_wk[3].c, i_cfg.sel_l, r_wk[3].off_l, 1'b0);
        n_wk[5].c = tcr_pkg::rotor_pass(refl, i_cfg.sel_l, r_wk[4].off_l, 1'b1);
        n_wk[6].c = tcr_pkg::rotor_pass(r_wk[5].c, i_cfg.sel_m, r_wk[5].off_m, 1'b1);
        n_wk[7].c = tcr_pkg::rotor_pass(r_wk[6].c, i_cfg.sel_r, r_wk[6].off_r, 1'b1);
        n_wk[8].c = c8;
        n_wk[9].c = c9;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (ld[k]) begin
                r_wk[k] <= n_wk[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= vin[k];
                end
            end
        end
    end

    assign o_valid          = r_vld[NSTG-1];
    assign o_cipher_letter  = r_wk[NSTG-1].c;
    assign o_right_pos_out  = r_wk[NSTG-1].pos_r;
    assign o_middle_pos_out = r_wk[NSTG-1].pos_m;
    assign o_left_pos_out   = r_wk[NSTG-1].pos_l;

endmodule

// ===== rtl/three_rotor_cipher_unit.sv =====
// Top level of the three-rotor cipher: configuration registers, front end, queue, pipeline.
//
//   channel   direction  handshake             payload
//   letter    in         i_valid / o_stall     i_letter
//   result    out        o_valid / i_stall     o_cipher_letter, o_*_pos_out
//   config    in         i_cfg_we              i_cfg_addr, i_cfg_wdata
//
// One letter is taken per cycle while o_stall is low; rotors step in the transfer's cycle.
// A result passes through the queue and then the ten-stage cipher pipeline.
// The queue between front end and pipeline holds QUEUE_DEPTH items, so each side stalls alone.
// Synchronous reset zeroes settings and positions; the plugboard is then identity.
module three_rotor_cipher_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [4:0]  i_letter,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_cipher_letter,
    output logic [4:0]  o_right_pos_out,
    output logic [4:0]  o_middle_pos_out,
    output logic [4:0]  o_left_pos_out,
    input  logic        i_cfg_we,
    input  logic [tcr_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [tcr_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [11:0] r_rotor_types;
    logic [1:0]  r_reflector;
    logic [14:0] r_ring;
    logic [tcr_pkg::CFG_DATA_W-1:0] r_pairs_a;
    logic [tcr_pkg::CFG_DATA_W-1:0] r_pairs_b;
    logic [29:0] r_pairs_c;

    tcr_pkg::t_cfg  cfg;
    logic           load;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_valid;
    tcr_pkg::t_item push_item;
    tcr_pkg::t_item head_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotor_types <= '0;
            r_reflector   <= '0;
            r_ring        <= '0;
            r_pairs_a     <= '0;
            r_pairs_b     <= '0;
            r_pairs_c     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tcr_pkg::CFG_ROTOR_TYPES:   r_rotor_types <= i_cfg_wdata[11:0];
                tcr_pkg::CFG_REFLECTOR:     r_reflector   <= i_cfg_wdata[1:0];
                tcr_pkg::CFG_RING_SETTINGS: r_ring        <= i_cfg_wdata[14:0];
                tcr_pkg::CFG_PLUG_PAIRS_A:  r_pairs_a     <= i_cfg_wdata;
                tcr_pkg::CFG_PLUG_PAIRS_B:  r_pairs_b     <= i_cfg_wdata;
                tcr_pkg::CFG_PLUG_PAIRS_C:  r_pairs_c     <= i_cfg_wdata[29:0];
                default: ;
            endcase
        end
    end

    assign load = i_cfg_we && (i_cfg_addr == tcr_pkg::CFG_START_POSITIONS);

    always_comb begin
        cfg.sel_r  = (r_rotor_types[3:0] > tcr_pkg::SEL_IDENTITY) ?
                     tcr_pkg::SEL_IDENTITY : r_rotor_types[3:0];
        cfg.sel_m  = (r_rotor_types[7:4] > tcr_pkg::SEL_IDENTITY) ?
                     tcr_pkg::SEL_IDENTITY : r_rotor_types[7:4];
        cfg.sel_l  = (r_rotor_types[11:8] > tcr_pkg::SEL_IDENTITY) ?
                     tcr_pkg::SEL_IDENTITY : r_rotor_types[11:8];
        cfg.refl   = (r_reflector > tcr_pkg::REFL_IDENTITY) ?
                     tcr_pkg::REFL_IDENTITY : r_reflector;
        cfg.ring_r = tcr_pkg::reduce26(r_ring[4:0]);
        cfg.ring_m = tcr_pkg::reduce26(r_ring[9:5]);
        cfg.ring_l = tcr_pkg::reduce26(r_ring[14:10]);
        cfg.pairs  = {r_pairs_c, r_pairs_b, r_pairs_a};
    end

    tcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_load     (load),
        .i_load_pos (i_cfg_wdata[14:0]),
        .i_valid    (i_valid),
        .i_letter   (i_letter),
        .o_stall    (o_stall),
        .i_full     (q_full),
        .o_push     (push),
        .o_item     (push_item)
    );

    tcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    tcr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_q_valid        (q_valid),
        .i_q_item         (head_item),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_cipher_letter  (o_cipher_letter),
        .o_right_pos_out  (o_right_pos_out),
        .o_middle_pos_out (o_middle_pos_out),
        .o_left_pos_out   (o_left_pos_out)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for three_rotor_cipher_unit, predicting each enciphered letter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ALPHABET = 26;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [4:0] cipher;
        logic [4:0] right_pos;
        logic [4:0] middle_pos;
        logic [4:0] left_pos;
    } t_cipher_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [4:0]  i_letter = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [4:0]  o_cipher_letter;
    logic [4:0]  o_right_pos_out;
    logic [4:0]  o_middle_pos_out;
    logic [4:0]  o_left_pos_out;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [49:0] i_cfg_wdata = '0;

    string rotor_wiring [9] = '{
        "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
        "AJDKSIRUXBLHWTMCQGZNPYFVOE",
        "BDFHJLCPRTXVZNYEIWGAKMUSQO",
        "ESOVPZJAYQUIRHXLNFTGKDCMWB",
        "VZBRGITYUPSDNHLXAWMJQOFECK",
        "JPGVOUMFYQBENHZRDKASXLICTW",
        "NZJHGRCXMYSWBOUFAIVLPEKQDT",
        "FKQHTLXOCBJSPDZRAMEWNIUYGV",
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ"
    };

    string reflector_wiring [3] = '{
        "YRUHQSLDPXNGOKMIEBFZCWVJAT",
        "FVPJIAOYEDRZXWGCTKUQSBNMHL",
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ"
    };

    logic [11:0] cfg_rotor_types;
    logic [1:0]  cfg_reflector;
    logic [14:0] cfg_rings;
    logic [49:0] cfg_plug_a;
    logic [49:0] cfg_plug_b;
    logic [29:0] cfg_plug_c;
    int          pos_right;
    int          pos_middle;
    int          pos_left;
    int          plugboard [ALPHABET];

    t_cipher_result expected_ciphers [$];
    t_cipher_result oldest_cipher;

    bit sender_gaps = 1'b0;
    bit receiver_gaps = 1'b0;
    int hold_request_cycles = 0;
    int letters_sent = 0;
    int ciphers_checked = 0;
    int settings_loaded = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    three_rotor_cipher_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_letter         (i_letter),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_cipher_letter  (o_cipher_letter),
        .o_right_pos_out  (o_right_pos_out),
        .o_middle_pos_out (o_middle_pos_out),
        .o_left_pos_out   (o_left_pos_out),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // The output side stalls in random bursts, or for a long hold when a test asks for one.
    initial begin : receiver
        int k;
        forever begin
            if (hold_request_cycles > 0) begin
                i_stall <= 1'b1;
                k = hold_request_cycles;
                hold_request_cycles = 0;
            end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                k = $urandom_range(1, 19);
            end else begin
                i_stall <= 1'b0;
                k = receiver_gaps ? $urandom_range(1, 8) : 1;
            end
            repeat (k) @(posedge i_clk);
        end
    end

    task automatic check_field(input string what, input logic [4:0] want, input logic [4:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_ciphers.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got letter %0d",
                         $time, o_cipher_letter);
                mismatches++;
            end else begin
                oldest_cipher = expected_ciphers.pop_front();
                check_field("cipher letter", oldest_cipher.cipher, o_cipher_letter);
                check_field("right position", oldest_cipher.right_pos, o_right_pos_out);
                check_field("middle position", oldest_cipher.middle_pos, o_middle_pos_out);
                check_field("left position", oldest_cipher.left_pos, o_left_pos_out);
                ciphers_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_ciphers.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int rotor_sel(input int slot);
        int s;
        s = int'(cfg_rotor_types[4*slot +: 4]);
        return (s > 8) ? 8 : s;
    endfunction

    function automatic bit notch_reached(input int sel, input int pos);
        case (sel) inside
            0: return pos == 16;
            1: return pos == 4;
            2: return pos == 21;
            3: return pos == 9;
            4: return pos == 25;
            5, 6, 7: return (pos == 12) || (pos == 25);
            default: return pos == 0;
        endcase
    endfunction

    function automatic int rotor_route(input int c, input int sel, input int pos, input int ring,
                                       input bit reverse);
        int idx;
        int v;
        idx = (c + pos + ALPHABET - ring) % ALPHABET;
        v = 0;
        if (!reverse) begin
            v = int'(rotor_wiring[sel][idx]) - 65;
        end else begin
            for (int i = 0; i < ALPHABET; i++) begin
                if (int'(rotor_wiring[sel][i]) - 65 == idx) begin
                    v = i;
                end
            end
        end
        return (v + ALPHABET - pos + ring) % ALPHABET;
    endfunction

    function automatic void rebuild_plugboard();
        logic [129:0] pairs;
        int lo;
        int hi;
        int t;
        pairs = {cfg_plug_c, cfg_plug_b, cfg_plug_a};
        for (int i = 0; i < ALPHABET; i++) begin
            plugboard[i] = i;
        end
        for (int k = 0; k < tcr_pkg::PAIR_COUNT; k++) begin
            lo = int'(pairs[10*k +: 5]);
            hi = int'(pairs[10*k+5 +: 5]);
            if (lo < ALPHABET && hi < ALPHABET) begin
                t = plugboard[lo];
                plugboard[lo] = plugboard[hi];
                plugboard[hi] = t;
            end
        end
    endfunction

    function automatic void clear_settings();
        cfg_rotor_types = '0;
        cfg_reflector = '0;
        cfg_rings = '0;
        cfg_plug_a = '0;
        cfg_plug_b = '0;
        cfg_plug_c = '0;
        pos_right = 0;
        pos_middle = 0;
        pos_left = 0;
        rebuild_plugboard();
    endfunction

    function automatic void apply_setting(input logic [2:0] idx, input logic [49:0] value);
        case (idx)
            tcr_pkg::CFG_ROTOR_TYPES: cfg_rotor_types = value[11:0];
            tcr_pkg::CFG_REFLECTOR: cfg_reflector = value[1:0];
            tcr_pkg::CFG_RING_SETTINGS: cfg_rings = value[14:0];
            tcr_pkg::CFG_START_POSITIONS: begin
                pos_right = int'(value[4:0]) % ALPHABET;
                pos_middle = int'(value[9:5]) % ALPHABET;
                pos_left = int'(value[14:10]) % ALPHABET;
            end
            tcr_pkg::CFG_PLUG_PAIRS_A: begin
                cfg_plug_a = value;
                rebuild_plugboard();
            end
            tcr_pkg::CFG_PLUG_PAIRS_B: begin
                cfg_plug_b = value;
                rebuild_plugboard();
            end
            tcr_pkg::CFG_PLUG_PAIRS_C: begin
                cfg_plug_c = value[29:0];
                rebuild_plugboard();
            end
            default: ;
        endcase
    endfunction

    function automatic t_cipher_result encipher(input logic [4:0] raw);
        int sel_r;
        int sel_m;
        int sel_l;
        int ring_r;
        int ring_m;
        int ring_l;
        int refl;
        int c;
        bit mid_turn;
        bit right_turn;
        t_cipher_result r;
        sel_r = rotor_sel(0);
        sel_m = rotor_sel(1);
        sel_l = rotor_sel(2);
        ring_r = int'(cfg_rings[4:0]) % ALPHABET;
        ring_m = int'(cfg_rings[9:5]) % ALPHABET;
        ring_l = int'(cfg_rings[14:10]) % ALPHABET;
        refl = (cfg_reflector > tcr_pkg::REFL_IDENTITY) ? int'(tcr_pkg::REFL_IDENTITY)
                                                        : int'(cfg_reflector);
        mid_turn = notch_reached(sel_m, pos_middle);
        right_turn = notch_reached(sel_r, pos_right);
        if (mid_turn) begin
            pos_left = (pos_left + 1) % ALPHABET;
        end
        if (mid_turn || right_turn) begin
            pos_middle = (pos_middle + 1) % ALPHABET;
        end
        pos_right = (pos_right + 1) % ALPHABET;
        c = plugboard[int'(raw) % ALPHABET];
        c = rotor_route(c, sel_r, pos_right, ring_r, 1'b0);
        c = rotor_route(c, sel_m, pos_middle, ring_m, 1'b0);
        c = rotor_route(c, sel_l, pos_left, ring_l, 1'b0);
        c = int'(reflector_wiring[refl][c]) - 65;
        c = rotor_route(c, sel_l, pos_left, ring_l, 1'b1);
        c = rotor_route(c, sel_m, pos_middle, ring_m, 1'b1);
        c = rotor_route(c, sel_r, pos_right, ring_r, 1'b1);
        c = plugboard[c];
        r.cipher = 5'(c);
        r.right_pos = 5'(pos_right);
        r.middle_pos = 5'(pos_middle);
        r.left_pos = 5'(pos_left);
        return r;
    endfunction

    function automatic logic [4:0] random_letter();
        return ($urandom_range(0, 15) == 0) ? 5'($urandom_range(26, 31))
                                            : 5'($urandom_range(0, 25));
    endfunction

    function automatic logic [49:0] random_pairs(input int count);
        logic [49:0] v;
        logic [4:0] lo;
        logic [4:0] hi;
        v = '0;
        for (int k = 0; k < count; k++) begin
            lo = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31))
                                             : 5'($urandom_range(0, 25));
            hi = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31))
                                             : 5'($urandom_range(0, 25));
            if ($urandom_range(0, 9) == 0) begin
                hi = lo;
            end
            v[10*k +: 10] = {hi, lo};
        end
        return v;
    endfunction

    task automatic send_letter(input logic [4:0] value);
        t_cipher_result want;
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_letter <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        want = encipher(value);
        expected_ciphers = {expected_ciphers, want};
        letters_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_ciphers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [49:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        apply_setting(idx, value);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [11:0] types, input logic [1:0] refl,
                                 input logic [14:0] rings, input logic [14:0] start,
                                 input logic [49:0] pairs_a, input logic [49:0] pairs_b,
                                 input logic [29:0] pairs_c);
        drain_results();
        write_register(tcr_pkg::CFG_ROTOR_TYPES, 50'(types));
        write_register(tcr_pkg::CFG_REFLECTOR, 50'(refl));
        write_register(tcr_pkg::CFG_RING_SETTINGS, 50'(rings));
        write_register(tcr_pkg::CFG_START_POSITIONS, 50'(start));
        write_register(tcr_pkg::CFG_PLUG_PAIRS_A, pairs_a);
        write_register(tcr_pkg::CFG_PLUG_PAIRS_B, pairs_b);
        write_register(tcr_pkg::CFG_PLUG_PAIRS_C, 50'(pairs_c));
        settings_loaded++;
    endtask

    task automatic load_random_settings();
        logic [11:0] types;
        logic [49:0] tail;
        for (int s = 0; s < 3; s++) begin
            types[4*s +: 4] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                          : 4'($urandom_range(0, 8));
        end
        tail = random_pairs(3);
        load_settings(types, 2'($urandom_range(0, 3)), 15'($urandom), 15'($urandom),
                      random_pairs(5), random_pairs(5), tail[29:0]);
    endtask

    task automatic test_reset_defaults();
        send_letter(5'd0);
        send_letter(5'd0);
        send_letter(5'd25);
        send_letter(5'd26);
        send_letter(5'd31);
        send_letter(5'd13);
    endtask

    // Rotors I, II, III from A-D-U walk through the double step of the middle rotor.
    task automatic test_double_step();
        load_settings(12'h012, 2'd0, 15'd0, {5'd0, 5'd3, 5'd20},
                      {10'd0, 10'd0, {5'd5, 5'd4}, {5'd3, 5'd2}, {5'd1, 5'd0}}, '0, '0);
        repeat (5) send_letter(5'd0);
    endtask

    // Rotors VI to VIII: the right rotor turns over at its Z notch and the middle rotor at its M notch.
    task automatic test_late_notch_rotors();
        load_settings({4'd7, 4'd5, 4'd6}, 2'd1, {5'd25, 5'd12, 5'd1}, {5'd25, 5'd11, 5'd24},
                      '0, '0, '0);
        send_letter(5'd1);
        send_letter(5'd2);
        send_letter(5'd3);
        send_letter(5'd4);
    endtask

    // Selects above the identity rotor, reflector code 3, out-of-range rings and positions,
    // an A-A pair, pairs naming letters above Z, and a letter reused across pairs.
    task automatic test_odd_settings();
        load_settings({4'd15, tcr_pkg::SEL_IDENTITY, 4'd9}, 2'd3, 15'h7FFF, 15'h7FFF,
                      {{5'd5, 5'd4}, {5'd4, 5'd31}, {5'd3, 5'd2}, {5'd2, 5'd1}, 10'd0},
                      '1, {{5'd0, 5'd25}, {5'd2, 5'd26}, {5'd25, 5'd3}});
        send_letter(5'd31);
        send_letter(5'd0);
        send_letter(5'd1);
        send_letter(5'd2);
        send_letter(5'd25);
        send_letter(5'd30);
    endtask

    task automatic test_random_settings();
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
        for (int phase = 0; phase < 12; phase++) begin
            if (phase == 0) begin
                load_settings('0, '0, '0, '0, '0, '0, '0);
            end else if (phase == 1) begin
                load_settings('1, '1, '1, '1, '1, '1, '1);
            end else begin
                load_random_settings();
            end
            repeat ($urandom_range(40, 60)) send_letter(random_letter());
        end
    endtask

    task automatic test_output_backpressure();
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        load_random_settings();
        hold_request_cycles = 150;
        repeat (40) send_letter(random_letter());
        drain_results();
    endtask

    task automatic test_full_rate();
        load_random_settings();
        repeat (140) send_letter(random_letter());
    endtask

    initial begin
        clear_settings();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_double_step();
        test_late_notch_rotors();
        test_odd_settings();
        test_random_settings();
        test_output_backpressure();
        test_full_rate();
        drain_results();
        $display("Enciphered %0d letters under %0d rotor and plugboard settings; %0d compared.",
                 letters_sent, settings_loaded + 1, ciphers_checked);
        $display("Runs included random stalls on both sides, a long output hold and a burst.");
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tcr_pkg.sv
rtl/tcr_front.sv
rtl/tcr_queue.sv
rtl/tcr_back.sv
rtl/three_rotor_cipher_unit.sv
tb/testbench.sv
